>>> design/ata_pkg.sv
package ata_pkg;

    localparam int CHANNELS_DEF = 2;
    localparam int WORDS_PER_SECTOR_DEF = 256;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_BUS_DATA = 2'd1,
        ACT_HOST_WORD = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        K_BUS_WRITE = 3'd0,
        K_BUS_READ = 3'd1,
        K_HOST_READ = 3'd2,
        K_DONE = 3'd3,
        K_NEED_WORDS = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ID_POLL,
        PH_ID_DISCARD,
        PH_XFER_POLL,
        PH_RD_DATA,
        PH_WR_WAIT,
        PH_FLUSH_POLL
    } phase_t;

    typedef enum logic [3:0] {
        SEQ_NONE,
        SEQ_START,
        SEQ_BAD_CHAN,
        SEQ_ID_DISCARD,
        SEQ_TASKFILE,
        SEQ_SINGLE,
        SEQ_RD_WORD,
        SEQ_WR_WORD
    } seq_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_FAULT = 2'd1,
        ST_NORESP = 2'd2
    } status_t;

    localparam logic [7:0] SB_ERR = 8'h01;
    localparam logic [7:0] SB_DRQ = 8'h08;
    localparam logic [7:0] SB_DF = 8'h20;
    localparam logic [7:0] SB_BSY = 8'h80;

    localparam logic [7:0] CMD_IDENTIFY = 8'hEC;
    localparam logic [7:0] CMD_READ_EXT = 8'h24;
    localparam logic [7:0] CMD_WRITE_EXT = 8'h34;
    localparam logic [7:0] CMD_FLUSH = 8'hE7;
    localparam logic [7:0] DEV_CHS = 8'hA0;
    localparam logic [7:0] DEV_LBA = 8'h40;

    localparam logic [2:0] R_DATA = 3'd0;
    localparam logic [2:0] R_COUNT = 3'd2;
    localparam logic [2:0] R_LBA0 = 3'd3;
    localparam logic [2:0] R_LBA1 = 3'd4;
    localparam logic [2:0] R_LBA2 = 3'd5;
    localparam logic [2:0] R_DRIVE = 3'd6;
    localparam logic [2:0] R_CMD = 3'd7;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] drive;
        logic       op_write;
        logic [47:0] lba;
        logic [15:0] sector_count;
        logic [15:0] data;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic        channel;
        logic [2:0]  bus_register;
        logic [15:0] bus_data;
        logic        bus_wide;
        logic [1:0]  status_code;
        logic        last;
    } result_t;

endpackage

>>> design/ata_queue.sv
module ata_queue #(
    parameter int DEPTH = ata_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  ata_pkg::item_t   in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output ata_pkg::item_t   out_item
);
    localparam int AW = $clog2(DEPTH);
    ata_pkg::item_t mem [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic push, pop;

    assign in_ready = cnt_reg != (AW+1)'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;
    assign out_item = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wp_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (AW+1)'(DEPTH)) else $error("queue overflow");
    no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == (AW+1)'(DEPTH) && !pop) |=> cnt_reg == (AW+1)'(DEPTH))
        else $error("queue count moved while full");
    empty_stays: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == '0 && !in_valid) |=> cnt_reg == '0)
        else $error("queue filled without push");
endmodule

>>> design/ata_front.sv
module ata_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_valid,
    output logic           s_ready,
    input  ata_pkg::item_t s_item,
    output logic           q_valid,
    input  logic           q_ready,
    output ata_pkg::item_t q_item
);
    logic drop;

    assign drop = s_item.action == ata_pkg::ACT_NONE;
    assign q_valid = s_valid && !drop;
    assign s_ready = q_ready || drop;
    assign q_item = s_item;

    no_code3: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid |-> q_item.action != ata_pkg::ACT_NONE)
        else $error("unused action forwarded");
    drop_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid && drop) |-> s_ready) else $error("unused action stalled");
    pass_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (s_valid && !drop) |-> (s_ready == q_ready))
        else $error("ready mismatch");
endmodule

>>> design/ata_back.sv
module ata_back #(
    parameter int CHANNELS = ata_pkg::CHANNELS_DEF,
    parameter int WORDS_PER_SECTOR = ata_pkg::WORDS_PER_SECTOR_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [3:0]      cfg_data,
    input  logic            q_valid,
    output logic            q_ready,
    input  ata_pkg::item_t  q_item,
    output logic            r_valid,
    input  logic            r_ready,
    output ata_pkg::result_t r_item
);
    localparam int WW = $clog2(WORDS_PER_SECTOR);

    ata_pkg::phase_t phase_reg, phase_next;
    ata_pkg::seq_t   seq_reg, seq_next;
    logic [3:0]  step_reg, step_next;
    logic [3:0]  poll_reg, poll_next;
    logic [WW-1:0] word_reg, word_next;
    logic [16:0] sect_reg, sect_next;
    logic        chan_reg, chan_next, slave_reg, slave_next, wr_reg, wr_next;
    logic [47:0] lba_reg, lba_next;
    logic [15:0] cnt_reg, cnt_next;
    logic [15:0] word_data_reg, word_data_next;
    logic [3:0]  rpr_reg, lpr_reg;
    ata_pkg::seq_t   tail_reg, tail_next;
    ata_pkg::result_t single_reg, single_next;
    ata_pkg::result_t cur;
    logic        busy, emit_last, out_adv, take;
    logic [7:0]  s;
    logic        last_word;
    logic [3:0]  rp_eff, lp_eff;
    logic [7:0]  lbyte;

    ata_pkg::result_t out_reg;
    logic        out_valid_reg;

    assign busy = seq_reg != ata_pkg::SEQ_NONE;
    assign out_adv = !out_valid_reg || r_ready;
    assign q_ready = !busy;
    assign take = q_valid && !busy;
    assign r_valid = out_valid_reg;
    assign r_item = out_reg;
    assign s = q_item.data[7:0];
    assign last_word = word_reg == WW'(WORDS_PER_SECTOR - 1);
    assign rp_eff = (rpr_reg == '0) ? 4'd1 : rpr_reg;
    assign lp_eff = (lpr_reg == '0) ? 4'd1 : lpr_reg;

    function automatic ata_pkg::result_t mk(input logic [2:0] k, input logic ch,
        input logic [2:0] rg, input logic [15:0] d, input logic w, input logic [1:0] c);
        ata_pkg::result_t r;
        r.kind = k;
        r.channel = ch;
        r.bus_register = rg;
        r.bus_data = d;
        r.bus_wide = w;
        r.status_code = c;
        r.last = 1'b0;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rpr_reg <= 4'd5;
            lpr_reg <= 4'd15;
        end
        else if (cfg_we)
        begin
            if (cfg_index)
            begin
                lpr_reg <= cfg_data;
            end
            else
            begin
                rpr_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        seq_next = seq_reg;
        step_next = step_reg;
        poll_next = poll_reg;
        word_next = word_reg;
        sect_next = sect_reg;
        chan_next = chan_reg;
        slave_next = slave_reg;
        wr_next = wr_reg;
        lba_next = lba_reg;
        cnt_next = cnt_reg;
        word_data_next = word_data_reg;
        tail_next = tail_reg;
        single_next = single_reg;
        cur = mk(ata_pkg::K_BUS_WRITE, chan_reg, '0, '0, 1'b0, '0);
        emit_last = 1'b0;
        lbyte = '0;

        if (take)
        begin
            unique case (q_item.action)
                ata_pkg::ACT_START:
                begin
                    chan_next = q_item.drive[1];
                    step_next = '0;
                    if (32'(q_item.drive[1]) >= CHANNELS)
                    begin
                        seq_next = ata_pkg::SEQ_BAD_CHAN;
                        phase_next = ata_pkg::PH_IDLE;
                        poll_next = '0;
                    end
                    else
                    begin
                        slave_next = q_item.drive[0];
                        wr_next = q_item.op_write;
                        lba_next = q_item.lba;
                        cnt_next = q_item.sector_count;
                        sect_next = (q_item.sector_count == '0) ? 17'h10000
                            : {1'b0, q_item.sector_count};
                        word_next = '0;
                        phase_next = ata_pkg::PH_ID_POLL;
                        poll_next = lp_eff;
                        seq_next = ata_pkg::SEQ_START;
                    end
                end
                ata_pkg::ACT_BUS_DATA:
                begin
                    unique case (phase_reg)
                        ata_pkg::PH_ID_POLL, ata_pkg::PH_XFER_POLL,
                        ata_pkg::PH_FLUSH_POLL:
                        begin
                            seq_next = ata_pkg::SEQ_SINGLE;
                            if (poll_reg > 4'd1)
                            begin
                                poll_next = poll_reg - 4'd1;
                                single_next = mk(ata_pkg::K_BUS_READ, chan_reg,
                                    ata_pkg::R_CMD, '0, 1'b0, '0);
                            end
                            else if (phase_reg == ata_pkg::PH_FLUSH_POLL)
                            begin
                                if ((s & ata_pkg::SB_BSY) == '0)
                                begin
                                    phase_next = ata_pkg::PH_IDLE;
                                    poll_next = '0;
                                    single_next = mk(ata_pkg::K_DONE, chan_reg,
                                        '0, '0, 1'b0, ata_pkg::ST_OK);
                                end
                                else
                                begin
                                    poll_next = lp_eff;
                                    single_next = mk(ata_pkg::K_BUS_READ, chan_reg,
                                        ata_pkg::R_CMD, '0, 1'b0, '0);
                                end
                            end
                            else if (phase_reg == ata_pkg::PH_ID_POLL && s == '0)
                            begin
                                phase_next = ata_pkg::PH_IDLE;
                                poll_next = '0;
                                single_next = mk(ata_pkg::K_DONE, chan_reg,
                                    '0, '0, 1'b0, ata_pkg::ST_NORESP);
                            end
                            else if ((s & (ata_pkg::SB_ERR | ata_pkg::SB_DF)) != '0)
                            begin
                                phase_next = ata_pkg::PH_IDLE;
                                poll_next = '0;
                                single_next = mk(ata_pkg::K_DONE, chan_reg,
                                    '0, '0, 1'b0, ata_pkg::ST_FAULT);
                            end
                            else if ((s & ata_pkg::SB_DRQ) != '0
                                && (s & ata_pkg::SB_BSY) == '0)
                            begin
                                poll_next = '0;
                                word_next = '0;
                                if (phase_reg == ata_pkg::PH_ID_POLL)
                                begin
                                    phase_next = ata_pkg::PH_ID_DISCARD;
                                    single_next = mk(ata_pkg::K_BUS_READ, chan_reg,
                                        ata_pkg::R_DATA, '0, 1'b1, '0);
                                end
                                else if (wr_reg)
                                begin
                                    phase_next = ata_pkg::PH_WR_WAIT;
                                    single_next = mk(ata_pkg::K_NEED_WORDS, chan_reg,
                                        '0, 16'(WORDS_PER_SECTOR), 1'b0, '0);
                                end
                                else
                                begin
                                    phase_next = ata_pkg::PH_RD_DATA;
                                    single_next = mk(ata_pkg::K_BUS_READ, chan_reg,
                                        ata_pkg::R_DATA, '0, 1'b1, '0);
                                end
                            end
                            else
                            begin
                                if (phase_reg == ata_pkg::PH_XFER_POLL)
                                begin
                                    poll_next = wr_reg ? lp_eff : rp_eff;
                                end
                                else
                                begin
                                    poll_next = lp_eff;
                                end
                                single_next = mk(ata_pkg::K_BUS_READ, chan_reg,
                                    ata_pkg::R_CMD, '0, 1'b0, '0);
                            end
                        end
                        ata_pkg::PH_ID_DISCARD:
                        begin
                            if (last_word)
                            begin
                                word_next = '0;
                                step_next = '0;
                                seq_next = ata_pkg::SEQ_TASKFILE;
                                phase_next = ata_pkg::PH_XFER_POLL;
                                poll_next = wr_reg ? lp_eff : rp_eff;
                            end
                            else
                            begin
                                word_next = word_reg + 1'b1;
                                seq_next = ata_pkg::SEQ_SINGLE;
                                single_next = mk(ata_pkg::K_BUS_READ, chan_reg,
                                    ata_pkg::R_DATA, '0, 1'b1, '0);
                            end
                        end
                        ata_pkg::PH_RD_DATA:
                        begin
                            word_data_next = q_item.data;
                            step_next = '0;
                            seq_next = ata_pkg::SEQ_RD_WORD;
                            if (last_word)
                            begin
                                word_next = '0;
                                sect_next = sect_reg - 17'd1;
                                if (sect_reg == 17'd1)
                                begin
                                    phase_next = ata_pkg::PH_IDLE;
                                    poll_next = '0;
                                    single_next = mk(ata_pkg::K_DONE, chan_reg,
                                        '0, '0, 1'b0, ata_pkg::ST_OK);
                                end
                                else
                                begin
                                    phase_next = ata_pkg::PH_XFER_POLL;
                                    poll_next = rp_eff;
                                    single_next = mk(ata_pkg::K_BUS_READ, chan_reg,
                                        ata_pkg::R_CMD, '0, 1'b0, '0);
                                end
                            end
                            else
                            begin
                                word_next = word_reg + 1'b1;
                                single_next = mk(ata_pkg::K_BUS_READ, chan_reg,
                                    ata_pkg::R_DATA, '0, 1'b1, '0);
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ata_pkg::ACT_HOST_WORD:
                begin
                    if (phase_reg == ata_pkg::PH_WR_WAIT)
                    begin
                        word_data_next = q_item.data;
                        step_next = '0;
                        seq_next = ata_pkg::SEQ_WR_WORD;
                        tail_next = ata_pkg::SEQ_NONE;
                        if (last_word)
                        begin
                            word_next = '0;
                            sect_next = sect_reg - 17'd1;
                            tail_next = ata_pkg::SEQ_SINGLE;
                            if (sect_reg == 17'd1)
                            begin
                                phase_next = ata_pkg::PH_FLUSH_POLL;
                                poll_next = lp_eff;
                                tail_next = ata_pkg::SEQ_START;
                            end
                            else
                            begin
                                phase_next = ata_pkg::PH_XFER_POLL;
                                poll_next = lp_eff;
                                single_next = mk(ata_pkg::K_BUS_READ, chan_reg,
                                    ata_pkg::R_CMD, '0, 1'b0, '0);
                            end
                        end
                        else
                        begin
                            word_next = word_reg + 1'b1;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (busy && out_adv)
        begin
            step_next = step_reg + 4'd1;
            unique case (seq_reg)
                ata_pkg::SEQ_START:
                begin
                    unique case (step_reg)
                        4'd0: cur = mk(ata_pkg::K_BUS_WRITE, chan_reg, ata_pkg::R_DRIVE,
                            {8'h00, ata_pkg::DEV_CHS | {3'b000, slave_reg, 4'h0}}, 1'b0, '0);
                        4'd1: cur = mk(ata_pkg::K_BUS_WRITE, chan_reg, ata_pkg::R_COUNT,
                            '0, 1'b0, '0);
                        4'd2: cur = mk(ata_pkg::K_BUS_WRITE, chan_reg, ata_pkg::R_LBA0,
                            '0, 1'b0, '0);
                        4'd3: cur = mk(ata_pkg::K_BUS_WRITE, chan_reg, ata_pkg::R_LBA1,
                            '0, 1'b0, '0);
                        4'd4: cur = mk(ata_pkg::K_BUS_WRITE, chan_reg, ata_pkg::R_LBA2,
                            '0, 1'b0, '0);
                        4'd5: cur = mk(ata_pkg::K_BUS_WRITE, chan_reg, ata_pkg::R_CMD,
                            {8'h00, ata_pkg::CMD_IDENTIFY}, 1'b0, '0);
                        default:
                        begin
                            cur = mk(ata_pkg::K_BUS_READ, chan_reg, ata_pkg::R_CMD,
                                '0, 1'b0, '0);
                            emit_last = 1'b1;
                        end
                    endcase
                end
                ata_pkg::SEQ_BAD_CHAN:
                begin
                    cur = mk(ata_pkg::K_DONE, chan_reg, '0, '0, 1'b0, ata_pkg::ST_NORESP);
                    emit_last = 1'b1;
                end
                ata_pkg::SEQ_SINGLE:
                begin
                    cur = single_reg;
                    emit_last = 1'b1;
                end
                ata_pkg::SEQ_TASKFILE:
                begin
                    unique case (step_reg)
                        4'd0: lbyte = ata_pkg::DEV_LBA | {3'b000, slave_reg, 4'h0};
                        4'd1: lbyte = cnt_reg[15:8];
                        4'd2: lbyte = lba_reg[31:24];
                        4'd3: lbyte = lba_reg[39:32];
                        4'd4: lbyte = lba_reg[47:40];
                        4'd5: lbyte = cnt_reg[7:0];
                        4'd6: lbyte = lba_reg[7:0];
                        4'd7: lbyte = lba_reg[15:8];
                        4'd8: lbyte = lba_reg[23:16];
                        default: lbyte = wr_reg ? ata_pkg::CMD_WRITE_EXT
                            : ata_pkg::CMD_READ_EXT;
                    endcase
                    unique case (step_reg)
                        4'd0: cur = mk(ata_pkg::K_BUS_WRITE, chan_reg, ata_pkg::R_DRIVE,
                            {8'h00, lbyte}, 1'b0, '0);
                        4'd1, 4'd5: cur = mk(ata_pkg::K_BUS_WRITE, chan_reg,
                            ata_pkg::R_COUNT, {8'h00, lbyte}, 1'b0, '0);
                        4'd2, 4'd6: cur = mk(ata_pkg::K_BUS_WRITE, chan_reg,
                            ata_pkg::R_LBA0, {8'h00, lbyte}, 1'b0, '0);
                        4'd3, 4'd7: cur = mk(ata_pkg::K_BUS_WRITE, chan_reg,
                            ata_pkg::R_LBA1, {8'h00, lbyte}, 1'b0, '0);
                        4'd4, 4'd8: cur = mk(ata_pkg::K_BUS_WRITE, chan_reg,
                            ata_pkg::R_LBA2, {8'h00, lbyte}, 1'b0, '0);
                        4'd9: cur = mk(ata_pkg::K_BUS_WRITE, chan_reg, ata_pkg::R_CMD,
                            {8'h00, lbyte}, 1'b0, '0);
                        default:
                        begin
                            cur = mk(ata_pkg::K_BUS_READ, chan_reg, ata_pkg::R_CMD,
                                '0, 1'b0, '0);
                            emit_last = 1'b1;
                        end
                    endcase
                end
                ata_pkg::SEQ_RD_WORD:
                begin
                    if (step_reg == '0)
                    begin
                        cur = mk(ata_pkg::K_HOST_READ, chan_reg, '0, word_data_reg,
                            1'b0, '0);
                    end
                    else
                    begin
                        cur = single_reg;
                        emit_last = 1'b1;
                    end
                end
                ata_pkg::SEQ_WR_WORD:
                begin
                    unique case (step_reg)
                        4'd0:
                        begin
                            cur = mk(ata_pkg::K_BUS_WRITE, chan_reg, ata_pkg::R_DATA,
                                word_data_reg, 1'b1, '0);
                            emit_last = tail_reg == ata_pkg::SEQ_NONE;
                        end
                        4'd1:
                        begin
                            if (tail_reg == ata_pkg::SEQ_SINGLE)
                            begin
                                cur = single_reg;
                                emit_last = 1'b1;
                            end
                            else
                            begin
                                cur = mk(ata_pkg::K_BUS_WRITE, chan_reg, ata_pkg::R_CMD,
                                    {8'h00, ata_pkg::CMD_FLUSH}, 1'b0, '0);
                            end
                        end
                        default:
                        begin
                            cur = mk(ata_pkg::K_BUS_READ, chan_reg, ata_pkg::R_CMD,
                                '0, 1'b0, '0);
                            emit_last = 1'b1;
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
            cur.last = emit_last;
            if (emit_last)
            begin
                seq_next = ata_pkg::SEQ_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= ata_pkg::PH_IDLE;
            seq_reg <= ata_pkg::SEQ_NONE;
            step_reg <= '0;
            poll_reg <= '0;
            word_reg <= '0;
            sect_reg <= '0;
            chan_reg <= 1'b0;
            slave_reg <= 1'b0;
            wr_reg <= 1'b0;
            lba_reg <= '0;
            cnt_reg <= '0;
            tail_reg <= ata_pkg::SEQ_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            seq_reg <= seq_next;
            step_reg <= step_next;
            poll_reg <= poll_next;
            word_reg <= word_next;
            sect_reg <= sect_next;
            chan_reg <= chan_next;
            slave_reg <= slave_next;
            wr_reg <= wr_next;
            lba_reg <= lba_next;
            cnt_reg <= cnt_next;
            tail_reg <= tail_next;
            if (!take && busy && out_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (r_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_data_reg <= word_data_next;
        single_reg <= single_next;
        if (!take && busy && out_adv)
        begin
            out_reg <= cur;
        end
    end

    no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !q_ready) else $error("accepted while sequencing");
    hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !r_ready) |=> $stable(out_reg))
        else $error("result changed under stall");
    poll_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == ata_pkg::PH_IDLE) |-> poll_reg == '0)
        else $error("poll count left in idle");
endmodule

>>> design/ata_pio_lba48_host_sequencer.sv
// ATA PIO LBA48 host sequencer. Each input word is taken into a four-entry queue by the
// front part; the back part turns one word into its burst of results, one result per
// cycle through a single output register while the output is not stalled, and takes
// the next word in the cycle after the last result of the previous one. A poll reply
// gives one result, a read data word two, a start seven and the task-file write
// eleven. Words with action code three are dropped at the front without results.
// Configuration writes go straight to the poll length registers and must be made
// while the block is idle.
module ata_pio_lba48_host_sequencer #(
    parameter int CHANNELS = ata_pkg::CHANNELS_DEF,
    parameter int WORDS_PER_SECTOR = ata_pkg::WORDS_PER_SECTOR_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    // action[1:0], drive[3:2], op_write[4], lba[52:5], sector_count[68:53], data[84:69]
    input  logic [87:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // channel[0], bus_register[3:1], bus_data[19:4], bus_wide[20], status_code[22:21]
    output logic [23:0] m_tdata,
    // kind[2:0]
    output logic [2:0]  m_tuser,
    output logic        m_tlast
);
    ata_pkg::item_t in_item, q_in, q_out;
    ata_pkg::result_t res;
    logic fq_valid, fq_ready, qb_valid, qb_ready;

    assign in_item.action = s_tdata[1:0];
    assign in_item.drive = s_tdata[3:2];
    assign in_item.op_write = s_tdata[4];
    assign in_item.lba = s_tdata[52:5];
    assign in_item.sector_count = s_tdata[68:53];
    assign in_item.data = s_tdata[84:69];

    ata_front u_front (
        .clk(clk), .rst_n(rst_n),
        .s_valid(s_tvalid), .s_ready(s_tready), .s_item(in_item),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_item(q_in)
    );

    ata_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .in_valid(fq_valid), .in_ready(fq_ready), .in_item(q_in),
        .out_valid(qb_valid), .out_ready(qb_ready), .out_item(q_out)
    );

    ata_back #(
        .CHANNELS(CHANNELS), .WORDS_PER_SECTOR(WORDS_PER_SECTOR)
    ) u_back (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .q_valid(qb_valid), .q_ready(qb_ready), .q_item(q_out),
        .r_valid(m_tvalid), .r_ready(m_tready), .r_item(res)
    );

    assign m_tdata = {1'b0, res.status_code, res.bus_wide, res.bus_data,
        res.bus_register, res.channel};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;
endmodule

>>> tb/ata_pio_lba48_host_sequencer_tb.sv
`timescale 1ns / 100ps

module ata_pio_lba48_host_sequencer_tb;

    localparam int CHAN_COUNT = 2;
    localparam int SECTOR_WORDS = 256;
    localparam int CYCLE_LIMIT = 1500000;
    localparam int SETTLE_CYCLES = 40;
    localparam logic CFG_READ_POLL = 1'b0;
    localparam logic CFG_LONG_POLL = 1'b1;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [3:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;

    ata_pio_lba48_host_sequencer uut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // sequencer image
    logic [3:0]  rd_reads;
    logic [3:0]  long_reads;
    ata_pkg::phase_t seq_phase;
    logic [3:0]  reads_left;
    logic [7:0]  word_idx;
    logic [16:0] sectors_todo;
    logic        act_channel;
    logic        act_slave;
    logic        act_write;
    logic [47:0] act_lba;
    logic [15:0] act_count;

    ata_pkg::result_t step_results[$];
    ata_pkg::result_t expected_results[$];
    logic [87:0] pending_words[$];

    int          fail_count;
    int          cycle_count;
    int          done_count;
    int          xfer_words;
    logic        in_fire;
    logic        out_fire;
    int          send_gap;
    int          recv_stall;
    logic        send_quiet;
    logic        recv_quiet;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void add_result(ata_pkg::kind_t k, logic [2:0] r, logic [15:0] d,
                                       logic w, ata_pkg::status_t c);
        ata_pkg::result_t x;
        x.kind = k;
        x.channel = act_channel;
        x.bus_register = r;
        x.bus_data = d;
        x.bus_wide = w;
        x.status_code = c;
        x.last = 1'b0;
        step_results.push_back(x);
    endfunction

    function automatic void bus_byte(logic [2:0] r, logic [7:0] b);
        add_result(ata_pkg::K_BUS_WRITE, r, {8'h00, b}, 1'b0, ata_pkg::ST_OK);
    endfunction

    function automatic void start_burst(logic [3:0] n);
        reads_left = (n != 4'd0) ? n : 4'd1;
        add_result(ata_pkg::K_BUS_READ, ata_pkg::R_CMD, 16'h0000, 1'b0, ata_pkg::ST_OK);
    endfunction

    function automatic void end_transfer(ata_pkg::status_t c);
        seq_phase = ata_pkg::PH_IDLE;
        reads_left = 4'd0;
        add_result(ata_pkg::K_DONE, ata_pkg::R_DATA, 16'h0000, 1'b0, c);
    endfunction

    function automatic logic burst_goes_on();
        if (reads_left > 4'd1)
        begin
            reads_left = reads_left - 4'd1;
            add_result(ata_pkg::K_BUS_READ, ata_pkg::R_CMD, 16'h0000, 1'b0,
                       ata_pkg::ST_OK);
            return 1'b1;
        end
        reads_left = 4'd0;
        return 1'b0;
    endfunction

    function automatic void sector_wait();
        seq_phase = ata_pkg::PH_XFER_POLL;
        start_burst(act_write ? long_reads : rd_reads);
    endfunction

    function automatic void predict_results(input logic [1:0] act, input logic [1:0] drv,
                                            input logic opw, input logic [47:0] lba,
                                            input logic [15:0] cnt, input logic [15:0] dat);
        logic [7:0] st;
        logic       last_word;
        st = dat[7:0];
        last_word = word_idx >= 8'(SECTOR_WORDS - 1);
        step_results.delete();
        if (act == ata_pkg::ACT_START)
        begin
            act_channel = drv[1];
            if (int'(drv[1]) >= CHAN_COUNT)
                end_transfer(ata_pkg::ST_NORESP);
            else
            begin
                act_slave = drv[0];
                act_write = opw;
                act_lba = lba;
                act_count = cnt;
                sectors_todo = (cnt != 16'd0) ? {1'b0, cnt} : 17'h10000;
                word_idx = 8'd0;
                bus_byte(ata_pkg::R_DRIVE, ata_pkg::DEV_CHS | {3'b000, act_slave, 4'h0});
                bus_byte(ata_pkg::R_COUNT, 8'h00);
                bus_byte(ata_pkg::R_LBA0, 8'h00);
                bus_byte(ata_pkg::R_LBA1, 8'h00);
                bus_byte(ata_pkg::R_LBA2, 8'h00);
                bus_byte(ata_pkg::R_CMD, ata_pkg::CMD_IDENTIFY);
                seq_phase = ata_pkg::PH_ID_POLL;
                start_burst(long_reads);
            end
        end
        else if (act == ata_pkg::ACT_BUS_DATA)
        begin
            case (seq_phase)
                ata_pkg::PH_ID_POLL:
                    if (!burst_goes_on())
                    begin
                        if (st == 8'h00)
                            end_transfer(ata_pkg::ST_NORESP);
                        else if ((st & (ata_pkg::SB_ERR | ata_pkg::SB_DF)) != 8'h00)
                            end_transfer(ata_pkg::ST_FAULT);
                        else if ((st & ata_pkg::SB_DRQ) != 8'h00
                                 && (st & ata_pkg::SB_BSY) == 8'h00)
                        begin
                            seq_phase = ata_pkg::PH_ID_DISCARD;
                            word_idx = 8'd0;
                            add_result(ata_pkg::K_BUS_READ, ata_pkg::R_DATA, 16'h0000, 1'b1,
                                       ata_pkg::ST_OK);
                        end
                        else
                            start_burst(long_reads);
                    end
                ata_pkg::PH_ID_DISCARD:
                    if (last_word)
                    begin
                        word_idx = 8'd0;
                        bus_byte(ata_pkg::R_DRIVE,
                                 ata_pkg::DEV_LBA | {3'b000, act_slave, 4'h0});
                        bus_byte(ata_pkg::R_COUNT, act_count[15:8]);
                        bus_byte(ata_pkg::R_LBA0, act_lba[31:24]);
                        bus_byte(ata_pkg::R_LBA1, act_lba[39:32]);
                        bus_byte(ata_pkg::R_LBA2, act_lba[47:40]);
                        bus_byte(ata_pkg::R_COUNT, act_count[7:0]);
                        bus_byte(ata_pkg::R_LBA0, act_lba[7:0]);
                        bus_byte(ata_pkg::R_LBA1, act_lba[15:8]);
                        bus_byte(ata_pkg::R_LBA2, act_lba[23:16]);
                        bus_byte(ata_pkg::R_CMD,
                                 act_write ? ata_pkg::CMD_WRITE_EXT : ata_pkg::CMD_READ_EXT);
                        sector_wait();
                    end
                    else
                    begin
                        word_idx = word_idx + 8'd1;
                        add_result(ata_pkg::K_BUS_READ, ata_pkg::R_DATA, 16'h0000, 1'b1,
                                   ata_pkg::ST_OK);
                    end
                ata_pkg::PH_XFER_POLL:
                    if (!burst_goes_on())
                    begin
                        if ((st & (ata_pkg::SB_ERR | ata_pkg::SB_DF)) != 8'h00)
                            end_transfer(ata_pkg::ST_FAULT);
                        else if ((st & ata_pkg::SB_DRQ) != 8'h00
                                 && (st & ata_pkg::SB_BSY) == 8'h00)
                        begin
                            word_idx = 8'd0;
                            if (act_write)
                            begin
                                seq_phase = ata_pkg::PH_WR_WAIT;
                                add_result(ata_pkg::K_NEED_WORDS, ata_pkg::R_DATA,
                                           16'(SECTOR_WORDS), 1'b0, ata_pkg::ST_OK);
                            end
                            else
                            begin
                                seq_phase = ata_pkg::PH_RD_DATA;
                                add_result(ata_pkg::K_BUS_READ, ata_pkg::R_DATA, 16'h0000,
                                           1'b1, ata_pkg::ST_OK);
                            end
                        end
                        else
                            sector_wait();
                    end
                ata_pkg::PH_RD_DATA:
                begin
                    add_result(ata_pkg::K_HOST_READ, ata_pkg::R_DATA, dat, 1'b0,
                               ata_pkg::ST_OK);
                    if (last_word)
                    begin
                        word_idx = 8'd0;
                        sectors_todo = sectors_todo - 17'd1;
                        if (sectors_todo == 17'd0)
                            end_transfer(ata_pkg::ST_OK);
                        else
                            sector_wait();
                    end
                    else
                    begin
                        word_idx = word_idx + 8'd1;
                        add_result(ata_pkg::K_BUS_READ, ata_pkg::R_DATA, 16'h0000, 1'b1,
                                   ata_pkg::ST_OK);
                    end
                end
                ata_pkg::PH_FLUSH_POLL:
                    if (!burst_goes_on())
                    begin
                        if ((st & ata_pkg::SB_BSY) == 8'h00)
                            end_transfer(ata_pkg::ST_OK);
                        else
                            start_burst(long_reads);
                    end
                default: ;
            endcase
        end
        else if (act == ata_pkg::ACT_HOST_WORD && seq_phase == ata_pkg::PH_WR_WAIT)
        begin
            add_result(ata_pkg::K_BUS_WRITE, ata_pkg::R_DATA, dat, 1'b1, ata_pkg::ST_OK);
            if (last_word)
            begin
                word_idx = 8'd0;
                sectors_todo = sectors_todo - 17'd1;
                if (sectors_todo == 17'd0)
                begin
                    bus_byte(ata_pkg::R_CMD, ata_pkg::CMD_FLUSH);
                    seq_phase = ata_pkg::PH_FLUSH_POLL;
                    start_burst(long_reads);
                end
                else
                    sector_wait();
            end
            else
                word_idx = word_idx + 8'd1;
        end
        if (step_results.size() > 0)
            step_results[step_results.size() - 1].last = 1'b1;
        foreach (step_results[i])
        begin
            if (step_results[i].kind == ata_pkg::K_DONE)
                done_count++;
            expected_results.push_back(step_results[i]);
        end
    endfunction

    task automatic queue_word(logic [1:0] act, logic [1:0] drv, logic opw, logic [47:0] lba,
                              logic [15:0] cnt, logic [15:0] dat);
        predict_results(act, drv, opw, lba, cnt, dat);
        pending_words.push_back({3'b000, dat, cnt, lba, opw, drv, act});
        xfer_words++;
    endtask

    task automatic queue_start(logic [15:0] cnt);
        xfer_words = 0;
        queue_word(ata_pkg::ACT_START, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   {16'($urandom), $urandom}, cnt, 16'($urandom));
    endtask

    function automatic logic [15:0] poll_status(logic flush);
        logic [15:0] d;
        int          pick;
        d = 16'($urandom);
        pick = $urandom_range(0, 9);
        if (flush)
            d[7] = (pick >= 7);
        else if (pick <= 5)
        begin
            d[7:0] = (d[7:0] & 8'h56) | ata_pkg::SB_DRQ;
        end
        else if (pick == 6)
            d[7:0] = (d[7:0] & 8'h5E) | ata_pkg::SB_BSY;
        else if (pick == 7)
            d[7:0] = d[7:0] | (d[0] ? ata_pkg::SB_ERR : ata_pkg::SB_DF);
        else if (pick == 8)
            d[7:0] = 8'h00;
        return d;
    endfunction

    task automatic queue_next();
        logic [15:0] d;
        logic [15:0] cnt;
        d = 16'($urandom);
        cnt = ($urandom_range(0, 30) == 0) ? 16'd0 : 16'($urandom_range(1, 2));
        if ($urandom_range(0, 12) == 0)
            queue_word(2'($urandom_range(0, 3)), 2'($urandom), 1'($urandom),
                       {16'($urandom), $urandom}, cnt, d);
        else if (seq_phase == ata_pkg::PH_IDLE || xfer_words > 900)
            queue_start(cnt);
        else if (seq_phase == ata_pkg::PH_WR_WAIT)
            queue_word(ata_pkg::ACT_HOST_WORD, 2'($urandom), 1'($urandom), 48'h0, 16'h0, d);
        else if ((seq_phase == ata_pkg::PH_ID_POLL || seq_phase == ata_pkg::PH_XFER_POLL ||
                  seq_phase == ata_pkg::PH_FLUSH_POLL) && reads_left <= 4'd1)
            queue_word(ata_pkg::ACT_BUS_DATA, 2'($urandom), 1'($urandom), 48'h0, 16'h0,
                       poll_status(seq_phase == ata_pkg::PH_FLUSH_POLL));
        else
            queue_word(ata_pkg::ACT_BUS_DATA, 2'($urandom), 1'($urandom), 48'h0, 16'h0, d);
    endtask

    task automatic drain_transfer();
        while (seq_phase != ata_pkg::PH_IDLE)
        begin
            if (seq_phase == ata_pkg::PH_ID_POLL || seq_phase == ata_pkg::PH_XFER_POLL ||
                seq_phase == ata_pkg::PH_FLUSH_POLL)
                queue_word(ata_pkg::ACT_BUS_DATA, 2'd0, 1'b0, 48'h0, 16'h0, 16'h0021);
            else
                queue_start(16'd1);
        end
    endtask

    task automatic wait_quiet();
        wait (pending_words.size() == 0 && !s_tvalid && expected_results.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [3:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == CFG_READ_POLL)
            rd_reads = val;
        else
            long_reads = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // word driver
    always @(posedge clk)
    begin
        in_fire <= s_tvalid && s_tready;
        out_fire <= m_tvalid && m_tready;
    end

    always @(negedge clk)
    begin
        if (rst_n && !(s_tvalid && !in_fire))
        begin
            if (in_fire)
            begin
                if ($urandom_range(0, 40) == 0)
                    send_quiet = !send_quiet;
                send_gap = send_quiet ? 0 : $urandom_range(0, 17);
            end
            if (send_gap > 0)
            begin
                send_gap--;
                s_tvalid <= 1'b0;
            end
            else if (pending_words.size() > 0)
            begin
                s_tdata <= pending_words.pop_front();
                s_tvalid <= 1'b1;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
            begin
                if ($urandom_range(0, 40) == 0)
                    recv_quiet = !recv_quiet;
                recv_stall = recv_quiet ? 0 : $urandom_range(0, 17);
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        ata_pkg::result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ata_pio_lba48_host_sequencer_tb failed");
            $finish;
        end
        else if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result kind %0d data %h", m_tuser, m_tdata);
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_tuser !== want.kind)
                begin
                    $error("kind expected %0d actual %0d", want.kind, m_tuser);
                    fail_count++;
                end
                if (m_tdata[0] !== want.channel)
                begin
                    $error("channel expected %0d actual %0d", want.channel, m_tdata[0]);
                    fail_count++;
                end
                if (m_tdata[3:1] !== want.bus_register)
                begin
                    $error("bus_register expected %0d actual %0d", want.bus_register,
                           m_tdata[3:1]);
                    fail_count++;
                end
                if (m_tdata[19:4] !== want.bus_data)
                begin
                    $error("bus_data expected %h actual %h", want.bus_data, m_tdata[19:4]);
                    fail_count++;
                end
                if (m_tdata[20] !== want.bus_wide)
                begin
                    $error("bus_wide expected %0d actual %0d", want.bus_wide, m_tdata[20]);
                    fail_count++;
                end
                if (m_tdata[22:21] !== want.status_code)
                begin
                    $error("status_code expected %0d actual %0d", want.status_code,
                           m_tdata[22:21]);
                    fail_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last expected %0d actual %0d", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        logic [3:0] rd_set[5];
        logic [3:0] long_set[5];
        rd_set = '{4'd5, 4'd1, 4'd15, 4'd0, 4'd3};
        long_set = '{4'd15, 4'd1, 4'd15, 4'd0, 4'd9};
        fail_count = 0;
        cycle_count = 0;
        done_count = 0;
        xfer_words = 0;
        send_gap = 0;
        recv_stall = 0;
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
        in_fire = 1'b0;
        out_fire = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_READ_POLL;
        cfg_data = 4'd0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        rd_reads = 4'd5;
        long_reads = 4'd15;
        seq_phase = ata_pkg::PH_IDLE;
        reads_left = 4'd0;
        word_idx = 8'd0;
        sectors_todo = 17'd0;
        act_channel = 1'b0;
        act_slave = 1'b0;
        act_write = 1'b0;
        act_lba = 48'h0;
        act_count = 16'h0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // stray words while idle, then abandoned starts at the field extremes
        queue_word(ata_pkg::ACT_BUS_DATA, 2'd0, 1'b0, 48'h0, 16'h0, 16'hFFFF);
        queue_word(ata_pkg::ACT_HOST_WORD, 2'd3, 1'b1, 48'hFFFF_FFFF_FFFF, 16'hFFFF,
                   16'hFFFF);
        queue_word(ata_pkg::ACT_NONE, 2'd3, 1'b1, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF);
        queue_word(ata_pkg::ACT_START, 2'd3, 1'b1, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF);
        queue_word(ata_pkg::ACT_HOST_WORD, 2'd0, 1'b0, 48'h0, 16'h0, 16'h1234);
        queue_word(ata_pkg::ACT_START, 2'd0, 1'b0, 48'h0, 16'h0, 16'h0000);
        repeat (14) queue_word(ata_pkg::ACT_BUS_DATA, 2'd0, 1'b0, 48'h0, 16'h0, 16'hFFFF);
        queue_word(ata_pkg::ACT_BUS_DATA, 2'd0, 1'b0, 48'h0, 16'h0, 16'hFF00);
        queue_word(ata_pkg::ACT_START, 2'd2, 1'b0, 48'h8000_0000_0001, 16'h0001, 16'h0);

        for (int p = 0; p < 5; p++)
        begin
            drain_transfer();
            wait_quiet();
            write_reg(CFG_READ_POLL, rd_set[p]);
            write_reg(CFG_LONG_POLL, long_set[p]);
            done_count = 0;
            for (int n = 0; n < 10 && done_count < 4; n++)
                queue_next();
        end
        drain_transfer();
        wait_quiet();
        if (fail_count == 0)
            $display("ata_pio_lba48_host_sequencer_tb passed");
        else
            $display("ata_pio_lba48_host_sequencer_tb failed");
        $finish;
    end

endmodule

>>> filelist.f
design/ata_pkg.sv
design/ata_queue.sv
design/ata_front.sv
design/ata_back.sv
design/ata_pio_lba48_host_sequencer.sv
tb/ata_pio_lba48_host_sequencer_tb.sv
